// File: rtl/core/mrgs_pkg.sv
package mrgs_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		STAT_PUSHED = 2'd0,
		STAT_POPPED = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_SETUP2,
		S_MERGE,
		S_POP_CHK,
		S_POP_RD
	} fsm_t;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		status_t                   status;
		logic                      last_out;
	} res_t;

endpackage

// File: rtl/core/mrgs_ram.sv
module mrgs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/merge_sort_int.sv
// Channel | Direction | Payload | Handshake
// cmd     | in        | cmd_t   | cmd_valid / cmd_ready
// res     | out       | res_t   | res_valid / res_ready
//
// A push is answered straight from S_IDLE; a pop from a sorted set passes S_POP_CHK and
// S_POP_RD, an empty pop S_POP_CHK only. The first pop after loading N elements first
// runs ceil(log2 N) merge passes, one element per cycle plus the S_SETUP and S_SETUP2
// states per pair of runs, set by the single write port of the destination buffer.
// Reset clears only the control state; the buffers need no clearing pass.
// A new command is taken while a result waits, as long as the output register frees.
module merge_sort_int #(
	parameter int unsigned MAX_ELEMS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  mrgs_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output mrgs_pkg::res_t res
);

	import mrgs_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ELEMS);
	localparam int unsigned CW = $clog2(MAX_ELEMS + 1);

	fsm_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ri_q, ri_d;
	logic          sorted_q, sorted_d;
	logic          src_b_q, src_b_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] width_q, width_d;
	logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;
	logic signed [DATA_W-1:0] head_l_q, head_l_d, head_r_q, head_r_d;
	logic          pend_l_q, pend_l_d, pend_r_q, pend_r_d;
	res_t          res_q, res_d;
	logic          res_valid_q, res_valid_d;

	logic              slot_free;
	logic              cmd_xfer;
	logic              rd_en;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rd_a, rd_b;
	logic signed [DATA_W-1:0] rd_data;
	logic              push_we, merge_we;
	logic [AW-1:0]     push_addr, merge_addr;
	logic [DATA_W-1:0] merge_wdata;

	logic [CW:0]   sum1, sum2, width2;
	logic [CW-1:0] mid_c, hi_c, eff_cnt;
	logic signed [DATA_W-1:0] hl, hr;
	logic          take_r;
	logic [CW-1:0] k_nx;

	assign slot_free = !res_valid_q || res_ready;
	assign cmd_ready = (state_q == S_IDLE) && slot_free;
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign rd_data = src_b_q ? $signed(rd_b) : $signed(rd_a);

	// Run bounds for the next pair of runs: mid = min(lo + width, n), hi = min(mid + width, n).
	assign sum1   = {1'b0, lo_q} + {1'b0, width_q};
	assign mid_c  = (sum1 < {1'b0, count_q}) ? sum1[CW-1:0] : count_q;
	assign sum2   = {1'b0, mid_c} + {1'b0, width_q};
	assign hi_c   = (sum2 < {1'b0, count_q}) ? sum2[CW-1:0] : count_q;
	assign width2 = {width_q, 1'b0};
	assign eff_cnt = sorted_q ? '0 : count_q;

	// A head whose read was issued last cycle comes straight from the RAM.
	assign hl     = pend_l_q ? rd_data : head_l_q;
	assign hr     = pend_r_q ? rd_data : head_r_q;
	assign take_r = (j_q < hi_q) && ((i_q >= mid_q) || (hl > hr));
	assign k_nx   = k_q + 1'b1;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ri_d        = ri_q;
		sorted_d    = sorted_q;
		src_b_d     = src_b_q;
		lo_d        = lo_q;
		width_d     = width_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		mid_d       = mid_q;
		hi_d        = hi_q;
		head_l_d    = head_l_q;
		head_r_d    = head_r_q;
		pend_l_d    = pend_l_q;
		pend_r_d    = pend_r_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && !res_ready;
		rd_en       = 1'b0;
		raddr       = '0;
		push_we     = 1'b0;
		push_addr   = eff_cnt[AW-1:0];
		merge_we    = 1'b0;
		merge_addr  = k_q[AW-1:0];
		merge_wdata = take_r ? hr : hl;

		case (state_q)
			S_IDLE: begin
				if (cmd_xfer) begin
					if (cmd.mode == MODE_PUSH) begin
						res_valid_d         = 1'b1;
						res_d.result_value  = '0;
						res_d.last_out      = 1'b0;
						if (sorted_q) begin
							sorted_d = 1'b0;
							ri_d     = '0;
							count_d  = '0;
						end
						if (eff_cnt >= CW'(MAX_ELEMS)) begin
							res_d.status = STAT_FULL;
						end else begin
							push_we      = 1'b1;
							count_d      = eff_cnt + 1'b1;
							res_d.status = STAT_PUSHED;
						end
					end else if (sorted_q) begin
						state_d = S_POP_CHK;
					end else begin
						src_b_d = 1'b0;
						ri_d    = '0;
						lo_d    = '0;
						width_d = CW'(1);
						if (count_q <= CW'(1)) begin
							sorted_d = 1'b1;
							state_d  = S_POP_CHK;
						end else begin
							state_d = S_SETUP;
						end
					end
				end
			end
			S_SETUP: begin
				rd_en   = 1'b1;
				raddr   = lo_q[AW-1:0];
				i_d     = lo_q;
				k_d     = lo_q;
				mid_d   = mid_c;
				j_d     = mid_c;
				hi_d    = hi_c;
				state_d = S_SETUP2;
			end
			S_SETUP2: begin
				// The right head may lie past the end; it is then never selected.
				rd_en    = 1'b1;
				raddr    = mid_q[AW-1:0];
				head_l_d = rd_data;
				pend_l_d = 1'b0;
				pend_r_d = 1'b1;
				state_d  = S_MERGE;
			end
			S_MERGE: begin
				merge_we = 1'b1;
				head_l_d = hl;
				head_r_d = hr;
				rd_en    = 1'b1;
				k_d      = k_nx;
				if (take_r) begin
					j_d      = j_q + 1'b1;
					raddr    = j_d[AW-1:0];
					pend_r_d = 1'b1;
					pend_l_d = 1'b0;
				end else begin
					i_d      = i_q + 1'b1;
					raddr    = i_d[AW-1:0];
					pend_l_d = 1'b1;
					pend_r_d = 1'b0;
				end
				if (k_nx == hi_q) begin
					if (hi_q >= count_q) begin
						src_b_d = !src_b_q;
						lo_d    = '0;
						width_d = width2[CW-1:0];
						if (width2 >= {1'b0, count_q}) begin
							sorted_d = 1'b1;
							state_d  = S_POP_CHK;
						end else begin
							state_d = S_SETUP;
						end
					end else begin
						lo_d    = hi_q;
						state_d = S_SETUP;
					end
				end
			end
			S_POP_CHK: begin
				if (ri_q >= count_q) begin
					if (slot_free) begin
						res_valid_d        = 1'b1;
						res_d.result_value = '0;
						res_d.status       = STAT_EMPTY;
						res_d.last_out     = 1'b0;
						state_d            = S_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					raddr   = ri_q[AW-1:0];
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: begin
				// The RAM holds its read data while no new read is issued.
				if (slot_free) begin
					res_valid_d        = 1'b1;
					res_d.result_value = rd_data;
					res_d.status       = STAT_POPPED;
					res_d.last_out     = (ri_q + 1'b1) == count_q;
					ri_d               = ri_q + 1'b1;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ri_q        <= '0;
			sorted_q    <= 1'b0;
			src_b_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ri_q        <= ri_d;
			sorted_q    <= sorted_d;
			src_b_q     <= src_b_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		width_q  <= width_d;
		i_q      <= i_d;
		j_q      <= j_d;
		k_q      <= k_d;
		mid_q    <= mid_d;
		hi_q     <= hi_d;
		head_l_q <= head_l_d;
		head_r_q <= head_r_d;
		pend_l_q <= pend_l_d;
		pend_r_q <= pend_r_d;
		res_q    <= res_d;
	end

	mrgs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ELEMS)
	) u_ram_a (
		.clk  (clk),
		.we   (push_we || (merge_we && src_b_q)),
		.waddr(push_we ? push_addr : merge_addr),
		.wdata(push_we ? cmd.value : merge_wdata),
		.re   (rd_en && !src_b_q),
		.raddr(raddr),
		.rdata(rd_a)
	);

	mrgs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ELEMS)
	) u_ram_b (
		.clk  (clk),
		.we   (merge_we && !src_b_q),
		.waddr(merge_addr),
		.wdata(merge_wdata),
		.re   (rd_en && src_b_q),
		.raddr(raddr),
		.rdata(rd_b)
	);

endmodule

// File: rtl/core/mrgs_chk.sv
module mrgs_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input mrgs_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_ready,
	input mrgs_pkg::res_t res
);

	import mrgs_pkg::*;

	// A stalled result stays on the port unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// Every push transfer answers in the very next cycle.
	a_push_answer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.mode == MODE_PUSH) |=>
		res_valid && ((res.status == STAT_PUSHED) || (res.status == STAT_FULL)))
		else $error("push without a push status");

	// Only a popped element may carry the last mark.
	a_last_popped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_out |-> res.status == STAT_POPPED)
		else $error("last mark on a non-pop result");

	// Results other than a popped element carry a zero value.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != STAT_POPPED) |-> res.result_value == '0)
		else $error("nonzero value on a non-pop result");

endmodule

bind merge_sort_int mrgs_chk u_mrgs_chk (.*);

// File: sim/merge_sort_int_tb.sv
`timescale 1ns / 1ps

module merge_sort_int_tb;
	import mrgs_pkg::*;

	localparam int unsigned CAPACITY = 1024;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	merge_sort_int #(
		.MAX_ELEMS(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Shadow of the block: the load set, its fill level and the pop position.
	logic signed [DATA_W-1:0] load_set [CAPACITY];
	int unsigned set_count = 0;
	int unsigned pop_idx = 0;
	bit set_sorted = 1'b0;
	res_t pending_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_cycles = 0;
	int unsigned items_sent = 0;
	int unsigned error_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("merge_sort_int_tb: done, errors");
		$finish;
	end

	// Insertion sort moves an element only past strictly greater ones, so it is
	// stable and yields the same order as the block's merge passes.
	function automatic void sort_load_set();
		int unsigned j;
		logic signed [DATA_W-1:0] key;
		for (int unsigned i = 1; i < set_count; i++) begin
			key = load_set[i];
			j = i;
			while (j > 0 && load_set[j-1] > key) begin
				load_set[j] = load_set[j-1];
				j--;
			end
			load_set[j] = key;
		end
	endfunction

	function automatic void predict_result(input cmd_t c);
		res_t r;
		r = '0;
		if (c.mode == MODE_PUSH) begin
			if (set_sorted) begin
				set_count = 0;
				pop_idx = 0;
				set_sorted = 1'b0;
			end
			if (set_count >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				load_set[set_count] = c.value;
				set_count++;
				r.status = STAT_PUSHED;
			end
		end else begin
			if (!set_sorted) begin
				sort_load_set();
				set_sorted = 1'b1;
				pop_idx = 0;
			end
			if (pop_idx >= set_count) begin
				r.status = STAT_EMPTY;
			end else begin
				r.result_value = load_set[pop_idx];
				pop_idx++;
				r.status = STAT_POPPED;
				r.last_out = (pop_idx == set_count);
			end
		end
		pending_results.push_back(r);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		int v;
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			2: begin
				// Narrow range so that sets hold many equal values.
				v = $urandom_range(0, 8);
				return v - 4;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	// Valid is lowered only when a gap follows, so a back-to-back transfer never
	// sees valid lowered and raised in the same step.
	task automatic send_cmd(input mode_t m, input logic signed [DATA_W-1:0] v);
		cmd_t c;
		int unsigned gap;
		c.mode = m;
		c.value = v;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 50)
			gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		predict_result(c);
		items_sent++;
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid === 1'b1 && res_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: value=%0d status=%0d last=%0b",
					$time, res.result_value, res.status, res.last_out);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (res.result_value !== want.result_value) begin
					$display("%0t: result_value mismatch: expected %0d, actual %0d",
						$time, want.result_value, res.result_value);
					error_count++;
				end
				if (res.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, res.status);
					error_count++;
				end
				if (res.last_out !== want.last_out) begin
					$display("%0t: last_out mismatch: expected %0b, actual %0b",
						$time, want.last_out, res.last_out);
					error_count++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic test_pop_never_loaded();
		send_cmd(MODE_POP, VAL_MAX);
		send_cmd(MODE_POP, '0);
	endtask

	task automatic test_extremes();
		send_cmd(MODE_PUSH, VAL_MAX);
		send_cmd(MODE_PUSH, VAL_MIN);
		send_cmd(MODE_PUSH, '0);
		send_cmd(MODE_PUSH, -1);
		send_cmd(MODE_PUSH, 1);
		send_cmd(MODE_PUSH, VAL_MIN);
		send_cmd(MODE_PUSH, VAL_MAX);
		repeat (9) send_cmd(MODE_POP, VAL_MIN);
	endtask

	task automatic test_push_while_popping();
		send_cmd(MODE_PUSH, 32'sd30);
		send_cmd(MODE_PUSH, -32'sd7);
		send_cmd(MODE_PUSH, 32'sd12);
		send_cmd(MODE_POP, '0);
		// The two remaining elements are discarded by the next push.
		send_cmd(MODE_PUSH, 32'sd5);
		send_cmd(MODE_PUSH, 32'sd5);
		repeat (3) send_cmd(MODE_POP, -1);
	endtask

	task automatic test_single_element();
		send_cmd(MODE_PUSH, -32'sd1000);
		send_cmd(MODE_POP, '0);
		send_cmd(MODE_POP, '0);
	endtask

	// A few pops check the head of the full sorted set; the next push drops the rest.
	task automatic test_full_store();
		repeat (CAPACITY) send_cmd(MODE_PUSH, rand_value());
		send_cmd(MODE_PUSH, VAL_MIN);
		send_cmd(MODE_PUSH, VAL_MAX);
		repeat (4) send_cmd(MODE_POP, $urandom);
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		repeat (10) send_cmd(MODE_PUSH, rand_value());
		repeat (11) send_cmd(MODE_POP, $urandom);
	endtask

	// Mostly whole sets (load, then pop until empty) with random content; the
	// rest is random commands and sets cut short by a new push.
	task automatic test_random_sets(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned budget);
		int unsigned start;
		int unsigned n;
		int unsigned pops;
		int unsigned pick;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				repeat ($urandom_range(1, 5))
					send_cmd(mode_t'($urandom_range(0, 1)), rand_value());
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					n = $urandom_range(1, 16);
				else if (pick < 95)
					n = $urandom_range(17, 64);
				else
					n = $urandom_range(65, 200);
				repeat (n) send_cmd(MODE_PUSH, rand_value());
				if ($urandom_range(0, 99) < 20)
					pops = $urandom_range(0, n - 1);
				else
					pops = n + $urandom_range(0, 2);
				repeat (pops) send_cmd(MODE_POP, $urandom);
			end
		end
	endtask

	initial begin
		int unsigned guard;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pop_never_loaded();
		test_extremes();
		test_push_while_popping();
		test_single_element();
		test_full_store();
		test_backpressure();
		test_random_sets(0, 0, 40);
		test_random_sets(56, 0, 40);
		test_random_sets(0, 56, 40);
		test_random_sets(37, 37, 40);

		cmd_valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("merge_sort_int_tb: done, clean");
		else
			$display("merge_sort_int_tb: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/core/mrgs_pkg.sv
rtl/core/mrgs_ram.sv
rtl/core/merge_sort_int.sv
rtl/core/mrgs_chk.sv
sim/merge_sort_int_tb.sv
